@@ hdl/dgsp_pkg.sv @@
// Shared types, constants and the digit font for the glyph to strip pixel block.
`default_nettype none
package dgsp_pkg;

  localparam int unsigned GLYPH_W = 3;
  localparam int unsigned GLYPH_H = 5;
  localparam int unsigned GLYPH_CELLS = GLYPH_W * GLYPH_H;

  localparam logic [7:0] LEVEL_ON = 8'd250;
  localparam logic [3:0] MAX_DIGIT = 4'd9;

  // Configuration register indexes.
  localparam logic [1:0] REG_COLUMN_HEIGHT = 2'd0;
  localparam logic [1:0] REG_BASE_INDEX    = 2'd1;
  localparam logic [1:0] REG_NUM_PIXELS    = 2'd2;

  localparam int unsigned CFG_DATA_W = 14;

  typedef struct packed {
    logic [3:0] digit;
    logic [5:0] origin_col;
    logic [5:0] origin_row;
    logic       lit;
  } in_t;

  typedef struct packed {
    logic signed [14:0] pixel_index;
    logic [7:0]         level;
    logic               on_strip;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [6:0]  column_height;
    logic [12:0] base_index;
    logic [13:0] num_pixels;
  } cfg_t;

  // One queued draw job: the glyph cells in raster order, top left cell in the MSB.
  typedef struct packed {
    logic [GLYPH_CELLS-1:0] mask;
    logic [5:0]             origin_col;
    logic [5:0]             origin_row;
    logic                   lit;
  } job_t;

  // Glyph rows top first, three bits each with the left pixel high.
  function automatic logic [GLYPH_CELLS-1:0] glyph_mask(input logic [3:0] digit);
    logic [GLYPH_CELLS-1:0] m;
    case (digit)
      4'd0:    m = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      4'd1:    m = {3'd2, 3'd2, 3'd2, 3'd2, 3'd2};
      4'd2:    m = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      4'd3:    m = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
      4'd4:    m = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      4'd5:    m = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      4'd6:    m = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
      4'd7:    m = {3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
      4'd8:    m = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      4'd9:    m = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

@@ hdl/digit_glyph_to_serpentine_pixels_top.sv @@
// Top level of the digit glyph to serpentine strip pixel block.
//
//   channel  ports                           handshake
//   in       start, busy, in_data            beat when start high and busy low
//   out      out_strobe, out_data            beat on every cycle out_strobe is high
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data   beat on valid and ready
//
// A draw command sits in the two entry queue until the scanner takes it; the scanner
// then loads it and scans one glyph cell per cycle up to the last set cell. Each
// pixel is registered on its way out. busy is high while the queue holds two jobs.
// Results cannot be stalled.
// Reset restores column height 21, base index 420 and strip length 441 and empties
// the queue.
`default_nettype none
module digit_glyph_to_serpentine_pixels_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire dgsp_pkg::in_t in_data,
  output logic               out_strobe,
  output dgsp_pkg::out_t     out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [13:0]   cfg_data
);
  import dgsp_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_full, q_empty, push, pop;
  job_t push_job, pop_job;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_COLUMN_HEIGHT: cfg_nxt.column_height = cfg_data[6:0];
        REG_BASE_INDEX:    cfg_nxt.base_index    = cfg_data[12:0];
        REG_NUM_PIXELS:    cfg_nxt.num_pixels    = cfg_data[13:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.column_height <= 7'd21;
      cfg_r.base_index    <= 13'd420;
      cfg_r.num_pixels    <= 14'd441;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dgsp_front u_front (
    .start    (start),
    .in_data  (in_data),
    .q_full   (q_full),
    .busy     (busy),
    .push     (push),
    .push_job (push_job)
  );

  dgsp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  dgsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .pop_job    (pop_job),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

@@ hdl/dgsp_front.sv @@
// Front end: takes draw commands, drops non-digits and looks up the glyph.
`default_nettype none
module dgsp_front (
  input  wire logic          start,
  input  wire dgsp_pkg::in_t in_data,
  input  wire logic          q_full,
  output logic               busy,
  output logic               push,
  output dgsp_pkg::job_t     push_job
);
  import dgsp_pkg::*;

  logic accept;

  assign busy   = q_full;
  assign accept = start && !q_full;

  // Codes above nine have no glyph and are consumed without a job.
  assign push = accept && (in_data.digit <= MAX_DIGIT);

  always_comb begin
    push_job.mask       = glyph_mask(in_data.digit);
    push_job.origin_col = in_data.origin_col;
    push_job.origin_row = in_data.origin_row;
    push_job.lit        = in_data.lit;
  end

endmodule
`default_nettype wire

@@ hdl/dgsp_queue.sv @@
// Two entry job queue between the front end and the scanner.
`default_nettype none
module dgsp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire dgsp_pkg::job_t push_job,
  input  wire logic           pop,
  output dgsp_pkg::job_t      pop_job,
  output logic                full,
  output logic                empty
);
  import dgsp_pkg::*;

  job_t       mem_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_job = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? ~wptr_r : wptr_r;
    rptr_nxt  = pop ? ~rptr_r : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

@@ hdl/dgsp_back.sv @@
// Back end: scans one glyph cell per cycle and emits a pixel for each set cell.
`default_nettype none
module dgsp_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire dgsp_pkg::cfg_t cfg,
  input  wire logic           q_empty,
  input  wire dgsp_pkg::job_t pop_job,
  output logic                pop,
  output logic                out_strobe,
  output dgsp_pkg::out_t      out_data
);
  import dgsp_pkg::*;

  logic                   active_r, active_nxt;
  logic [GLYPH_CELLS-1:0] mask_r, mask_nxt;
  logic [1:0]             dc_r, dc_nxt;
  logic [2:0]             dr_r, dr_nxt;
  logic [5:0]             col_r, row_r;
  logic                   lit_r;
  logic                   strobe_r, strobe_nxt;
  out_t                   data_r, data_nxt;

  logic [6:0]         cur_col, cur_row, even_col;
  logic [13:0]        prod;
  logic signed [15:0] base_s, row_s, prod_s, idx_s;
  logic               cell_set, rest_empty, on_strip;

  assign pop = !active_r && !q_empty;

  always_comb begin
    cur_col  = {1'b0, col_r} + {5'd0, dc_r};
    cur_row  = {1'b0, row_r} + {4'd0, dr_r};
    // Odd columns run up from the top of the even column to their left.
    even_col = {cur_col[6:1], 1'b0};
    prod     = {7'd0, even_col} * {7'd0, cfg.column_height};
    base_s   = $signed({3'b000, cfg.base_index});
    row_s    = $signed({9'd0, cur_row});
    prod_s   = $signed({2'b00, prod});
    if (cur_col[0]) begin
      idx_s = base_s - 16'sd1 - row_s - prod_s;
    end else begin
      idx_s = base_s + row_s - prod_s;
    end
    on_strip = !idx_s[15] && (idx_s[14:0] < {1'b0, cfg.num_pixels});

    cell_set   = mask_r[GLYPH_CELLS-1];
    rest_empty = (mask_r[GLYPH_CELLS-2:0] == '0);

    data_nxt.pixel_index = idx_s[14:0];
    data_nxt.level       = lit_r ? LEVEL_ON : 8'd0;
    data_nxt.on_strip    = on_strip;
    data_nxt.last        = rest_empty;
  end

  always_comb begin
    active_nxt = active_r;
    mask_nxt   = mask_r;
    dc_nxt     = dc_r;
    dr_nxt     = dr_r;
    strobe_nxt = 1'b0;
    if (active_r) begin
      strobe_nxt = cell_set;
      mask_nxt   = {mask_r[GLYPH_CELLS-2:0], 1'b0};
      if (dc_r == 2'(GLYPH_W - 1)) begin
        dc_nxt = 2'd0;
        dr_nxt = dr_r + 3'd1;
      end else begin
        dc_nxt = dc_r + 2'd1;
      end
      // Stop as soon as no set cell remains further down the glyph.
      if (rest_empty) begin
        active_nxt = 1'b0;
      end
    end else if (pop) begin
      active_nxt = 1'b1;
      mask_nxt   = pop_job.mask;
      dc_nxt     = 2'd0;
      dr_nxt     = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    dc_r   <= dc_nxt;
    dr_r   <= dr_nxt;
    data_r <= data_nxt;
    if (pop) begin
      col_r <= pop_job.origin_col;
      row_r <= pop_job.origin_row;
      lit_r <= pop_job.lit;
    end
  end

  assign out_strobe = strobe_r;
  assign out_data   = data_r;

endmodule
`default_nettype wire

@@ sim/dgsp_pixel_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard that predicts every pixel beat of the glyph to strip block and compares it.
module dgsp_pixel_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  dgsp_pkg::in_t    in_data,
  input  logic             out_strobe,
  input  dgsp_pkg::out_t   out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [13:0]      cfg_data,
  output int               fail_count,
  output int               pixels_pending,
  output int               pixels_checked
);
  import dgsp_pkg::*;

  localparam logic [6:0]  RESET_HEIGHT = 7'd21;
  localparam logic [12:0] RESET_BASE   = 13'd420;
  localparam logic [13:0] RESET_LENGTH = 14'd441;
  localparam int          PRINT_LIMIT  = 30;

  // Fifteen cells per digit in raster order, top left cell in the high bit; digit 0 lowest.
  localparam logic [149:0] DIGIT_FONT = {
    15'b111_101_111_001_111,  // 9
    15'b111_101_111_101_111,  // 8
    15'b111_001_001_001_001,  // 7
    15'b111_100_111_101_111,  // 6
    15'b111_100_111_001_111,  // 5
    15'b101_101_111_001_001,  // 4
    15'b111_001_111_001_111,  // 3
    15'b111_001_111_100_111,  // 2
    15'b010_010_010_010_010,  // 1
    15'b111_101_101_101_111   // 0
  };

  logic [6:0]  stride;
  logic [12:0] base;
  logic [13:0] strip_len;
  out_t        expected_pixels[$];
  int          mismatches;
  int          compared;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t ns: pixel mismatch: %s", $time, what);
    end
  endtask

  function automatic void predict_glyph_pixels(input in_t cmd);
    logic [14:0] cells;
    int          last_cell;
    int          k;
    int          c;
    int          r;
    int          idx;
    out_t        px;
    if (cmd.digit > MAX_DIGIT) return;
    cells = DIGIT_FONT[cmd.digit * 15 +: 15];
    last_cell = -1;
    for (k = 0; k < GLYPH_CELLS; k++) begin
      if (cells[14 - k]) last_cell = k;
    end
    for (k = 0; k < GLYPH_CELLS; k++) begin
      if (cells[14 - k]) begin
        c = int'(cmd.origin_col) + k % GLYPH_W;
        r = int'(cmd.origin_row) + k / GLYPH_W;
        // Even columns run down the strip, odd columns run back up.
        if (c % 2 == 0) begin
          idx = int'(base) - c * int'(stride) + r;
        end else begin
          idx = int'(base) - 1 - (c - 1) * int'(stride) - r;
        end
        px.pixel_index = idx[14:0];
        px.level       = cmd.lit ? LEVEL_ON : 8'd0;
        px.on_strip    = (idx >= 0) && (idx < int'(strip_len));
        px.last        = (k == last_cell);
        expected_pixels.push_back(px);
      end
    end
  endfunction

  task automatic check_pixel(input out_t got);
    out_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("beat with nothing expected, index %0d", got.pixel_index));
      return;
    end
    want = expected_pixels.pop_front();
    compared++;
    if (got.pixel_index !== want.pixel_index) begin
      report_mismatch($sformatf("pixel_index got %0d want %0d",
                                got.pixel_index, want.pixel_index));
    end
    if (got.level !== want.level) begin
      report_mismatch($sformatf("level got %0d want %0d at index %0d",
                                got.level, want.level, want.pixel_index));
    end
    if (got.on_strip !== want.on_strip) begin
      report_mismatch($sformatf("on_strip got %b want %b at index %0d",
                                got.on_strip, want.on_strip, want.pixel_index));
    end
    if (got.last !== want.last) begin
      report_mismatch($sformatf("last got %b want %b at index %0d",
                                got.last, want.last, want.pixel_index));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stride    = RESET_HEIGHT;
      base      = RESET_BASE;
      strip_len = RESET_LENGTH;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COLUMN_HEIGHT: stride    = cfg_data[6:0];
          REG_BASE_INDEX:    base      = cfg_data[12:0];
          REG_NUM_PIXELS:    strip_len = cfg_data;
          default: ;
        endcase
      end
      // A result beat always belongs to an earlier command, so check before predicting.
      if (out_strobe) check_pixel(out_data);
      if (start && !busy) predict_glyph_pixels(in_data);
    end
    fail_count     <= mismatches;
    pixels_pending <= expected_pixels.size();
    pixels_checked <= compared;
  end

endmodule

@@ sim/digit_glyph_to_serpentine_pixels_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top: drives draw commands and register writes and gives the verdict.
module digit_glyph_to_serpentine_pixels_top_tb;
  import dgsp_pkg::*;

  localparam int         STALL_LIMIT     = 4000;
  localparam int         DRAIN_CYCLES    = 40;
  localparam int         PHASE_DRAWS     = 45;
  localparam int         SETTINGS_PHASES = 7;
  localparam logic [1:0] REG_UNUSED      = 2'd3;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  in_t         in_data   = '0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = REG_COLUMN_HEIGHT;
  logic [13:0] cfg_data  = '0;
  logic        busy;
  logic        out_strobe;
  out_t        out_data;
  logic        cfg_ready;

  int fail_count;
  int pixels_pending;
  int pixels_checked;
  int draws_sent;
  int blanks_sent;
  int idle_cycles;
  bit gaps_on;

  always #2 clk = ~clk;

  digit_glyph_to_serpentine_pixels_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dgsp_pixel_checker pixel_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_data        (in_data),
    .out_strobe     (out_strobe),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pixels_pending (pixels_pending),
    .pixels_checked (pixels_checked)
  );

  // Ends the run when no beat of any channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[digit_glyph_to_serpentine_pixels_top] ERROR");
        $finish;
      end
    end
  end

  function automatic in_t draw_cmd(input int digit, input int col, input int row,
                                   input int lit);
    in_t cmd;
    cmd.digit      = digit[3:0];
    cmd.origin_col = col[5:0];
    cmd.origin_row = row[5:0];
    cmd.lit        = lit[0];
    return cmd;
  endfunction

  // Start stays high across back to back beats; it only drops when a gap follows.
  task automatic send_and_pace(input in_t cmd);
    int roll;
    int gap;
    start   <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd.digit > MAX_DIGIT) blanks_sent++;
    else draws_sent++;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 55) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Once every pixel is back, a quiet drain period separates the traffic from the next writes.
  task automatic wait_for_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [13:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Unused upper data bits carry noise, which the block must drop.
  task automatic program_registers(input logic [6:0] height, input logic [12:0] base,
                                   input logic [13:0] length, input bit poke_unused);
    logic [13:0] noise;
    noise = 14'($urandom);
    write_register(REG_COLUMN_HEIGHT, {noise[13:7], height});
    write_register(REG_BASE_INDEX, {noise[0], base});
    write_register(REG_NUM_PIXELS, length);
    if (poke_unused) write_register(REG_UNUSED, noise);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int target;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: every digit, the field extremes, erase, and indexes off both ends.
    gaps_on = 1'b1;
    send_and_pace(draw_cmd(0, 0, 0, 1));
    send_and_pace(draw_cmd(1, 1, 0, 1));
    send_and_pace(draw_cmd(2, 2, 5, 0));
    send_and_pace(draw_cmd(3, 19, 16, 1));
    send_and_pace(draw_cmd(4, 20, 10, 1));
    send_and_pace(draw_cmd(5, 21, 0, 1));
    send_and_pace(draw_cmd(6, 63, 63, 1));
    send_and_pace(draw_cmd(7, 0, 63, 0));
    send_and_pace(draw_cmd(10, 5, 5, 1));
    send_and_pace(draw_cmd(8, 10, 30, 1));
    send_and_pace(draw_cmd(9, 63, 0, 0));
    send_and_pace(draw_cmd(15, 63, 63, 1));
    send_and_pace(draw_cmd(12, 0, 0, 0));
    send_and_pace(draw_cmd(8, 62, 62, 1));
    send_and_pace(draw_cmd(0, 33, 7, 0));
    send_and_pace(draw_cmd(11, 1, 1, 1));
    send_and_pace(draw_cmd(13, 40, 40, 0));
    send_and_pace(draw_cmd(14, 2, 2, 1));
    send_and_pace(draw_cmd(9, 1, 1, 1));
    send_and_pace(draw_cmd(4, 63, 32, 0));
    wait_for_idle();

    for (phase = 1; phase <= SETTINGS_PHASES; phase++) begin
      case (phase)
        1: program_registers(7'd0, 13'd0, 14'd0, 1'b1);
        2: program_registers(7'd127, 13'd8191, 14'd16383, 1'b0);
        3: program_registers(7'd1, 13'd8191, 14'd8192, 1'b0);
        4: program_registers(7'd64, 13'd0, 14'd1, 1'b0);
        5: program_registers(7'($urandom_range(1, 64)), 13'($urandom_range(0, 8191)),
                             14'($urandom_range(1, 8192)), 1'b0);
        6: program_registers(7'($urandom), 13'($urandom), 14'($urandom), 1'b1);
        default: program_registers(7'd21, 13'd420, 14'd441, 1'b0);
      endcase
      gaps_on = (phase != 2) && ($urandom_range(0, 3) != 0);
      target = draws_sent + PHASE_DRAWS;
      while (draws_sent < target) begin
        if ($urandom_range(0, 99) < 88) begin
          send_and_pace(draw_cmd($urandom_range(0, 9), $urandom_range(0, 63),
                                 $urandom_range(0, 63), $urandom_range(0, 1)));
        end else begin
          send_and_pace(draw_cmd($urandom_range(10, 15), $urandom_range(0, 63),
                                 $urandom_range(0, 63), $urandom_range(0, 1)));
        end
        // Now and then hold the sender back until every pixel has drained.
        if (($urandom_range(0, 59) == 0) || (phase == 3 && draws_sent == target - 20)) begin
          wait_for_idle();
        end
      end
      wait_for_idle();
    end

    $display("Sent %0d digit and %0d non-digit draw commands under %0d register settings.",
             draws_sent, blanks_sent, SETTINGS_PHASES + 1);
    $display("Compared %0d pixel beats, with zero stride, empty strip and off-strip indexes.",
             pixels_checked);
    if (fail_count == 0) begin
      $display("[digit_glyph_to_serpentine_pixels_top] OK");
    end else begin
      $display("[digit_glyph_to_serpentine_pixels_top] ERROR");
    end
    $finish;
  end

endmodule

@@ digit_glyph_to_serpentine_pixels_top.f @@
hdl/dgsp_pkg.sv
hdl/dgsp_front.sv
hdl/dgsp_queue.sv
hdl/dgsp_back.sv
hdl/digit_glyph_to_serpentine_pixels_top.sv
sim/dgsp_pixel_checker.sv
sim/digit_glyph_to_serpentine_pixels_top_tb.sv
